// ===== rtl/qpd_pkg.sv =====
// Shared types and constants of the quasi-peak detector.
package qpd_pkg;

    // Width of the dB result and of the log2 fraction.
    localparam int DB_W       = 16;
    localparam int LOG_FRAC_W = 16;
    // Normalised mantissa: Q30 with the leading one at bit 30.
    localparam int MANT_W     = 31;
    localparam int SQR_CNT_W  = 4;

    // 128 * 20 * log10(2) in Q16.
    localparam logic signed [26:0] DB_Q16 = 27'sd50504453;

    // Result saturation limits.
    localparam int DB_MAX = 32767;
    localparam int DB_MIN = -32768;

    // Coefficient values after reset, in the 24-fraction-bit format.
    localparam int CHARGE_COEF_RST    = 16777;
    localparam int DISCHARGE_COEF_RST = 105;

    // Configuration register map.
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHARGE_COEF    = 2'd0,
        CFG_DISCHARGE_COEF = 2'd1
    } t_cfg_idx;

    // Euler step sequencer.
    typedef enum logic [1:0] {
        STEP_IDLE,
        STEP_MUL,
        STEP_SUM,
        STEP_UPD
    } t_step_state;

    // Level to dB converter.
    typedef enum logic [2:0] {
        LOG_IDLE,
        LOG_NORM,
        LOG_SQR,
        LOG_MUL,
        LOG_RND,
        LOG_HOLD
    } t_log_state;

endpackage

// ===== rtl/qpd_if.sv =====
// Channel interfaces of the quasi-peak detector: samples, results and configuration.
interface qpd_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface qpd_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [qpd_pkg::DB_W-1:0]   level_db;

    modport source (output valid, output level_db, input ready);
    modport sink   (input valid, input level_db, output ready);
endinterface

interface qpd_cfg_if #(
    parameter int COEF_FRAC_BITS = 24
);
    logic                              valid;
    logic                              ready;
    logic [qpd_pkg::CFG_IDX_W-1:0]     index;
    logic [COEF_FRAC_BITS:0]           data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/quasi_peak_detector.sv =====
// Quasi-peak detector top level: configuration registers, queue and step and dB units.
//
// Each sample transaction carries a signed microvolt sample and a flag for
// the last sample of an observation run. The front end rectifies the sample
// (the most negative code saturates to the largest positive magnitude) and
// places it in a two-entry queue, so the input keeps taking transactions
// while the back end is busy until the queue is full. The Euler step
// sequencer takes one queued sample at a time through an operand and compare
// cycle, a multiply cycle in which the operand is split at the binary point
// into two narrow products, a sum cycle and a level update cycle, and takes
// no new sample until the held level is updated. On the last sample of a
// run the updated level is handed to the dB converter and the held level is
// cleared, so the next run starts at once. The converter normalises the
// level (one bit of shift per cycle), squares repeatedly for the log2
// fraction, and then scales and rounds, after which the result waits in its
// output register until the result transaction completes. A further last
// sample arriving while the converter is still busy holds the step
// sequencer in its update cycle until the converter is free. A zero level
// reports 0 dB.
// Coefficient writes are capped at 1.0 and must only be made while the block
// is idle; a write to an unused register index is ignored.
module quasi_peak_detector #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 24
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qpd_in_if.sink    i_in,
    qpd_out_if.source o_out,
    qpd_cfg_if.sink   i_cfg
);
    import qpd_pkg::*;

    localparam int LEVEL_W = SAMPLE_BITS - 1 + COEF_FRAC_BITS;
    localparam logic [COEF_FRAC_BITS:0] COEF_ONE = {1'b1, {COEF_FRAC_BITS{1'b0}}};

    // Coefficient registers, written through the configuration channel.
    logic [COEF_FRAC_BITS:0] r_charge_coef;
    logic [COEF_FRAC_BITS:0] r_discharge_coef;
    logic [COEF_FRAC_BITS:0] cfg_capped;

    // Front end to queue.
    logic                   push;
    logic                   q_full;
    logic [SAMPLE_BITS-2:0] front_mag;
    logic                   front_last;

    // Queue to step sequencer.
    logic                   q_valid;
    logic                   q_pop;
    logic [SAMPLE_BITS-1:0] q_data;

    // Step sequencer to dB converter.
    logic                   log_ready;
    logic                   log_start;
    logic [LEVEL_W-1:0]     run_level;

    // The configuration channel never stalls.
    assign i_cfg.ready = 1'b1;
    assign cfg_capped  = (i_cfg.data > COEF_ONE) ? COEF_ONE : i_cfg.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_charge_coef    <= (COEF_FRAC_BITS + 1)'(CHARGE_COEF_RST);
            r_discharge_coef <= (COEF_FRAC_BITS + 1)'(DISCHARGE_COEF_RST);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_CHARGE_COEF: begin
                    r_charge_coef <= cfg_capped;
                end
                CFG_DISCHARGE_COEF: begin
                    r_discharge_coef <= cfg_capped;
                end
                default: begin
                end
            endcase
        end
    end

    qpd_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_in   (i_in),
        .i_full (q_full),
        .o_push (push),
        .o_mag  (front_mag),
        .o_last (front_last)
    );

    qpd_fifo #(
        .WIDTH (SAMPLE_BITS)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({front_last, front_mag}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    qpd_step #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .LEVEL_W        (LEVEL_W)
    ) u_step (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .o_q_pop          (q_pop),
        .i_mag            (q_data[SAMPLE_BITS-2:0]),
        .i_last           (q_data[SAMPLE_BITS-1]),
        .i_charge_coef    (r_charge_coef),
        .i_discharge_coef (r_discharge_coef),
        .i_log_ready      (log_ready),
        .o_log_start      (log_start),
        .o_level          (run_level)
    );

    qpd_log #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .LEVEL_W        (LEVEL_W)
    ) u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (log_start),
        .i_level (run_level),
        .o_ready (log_ready),
        .o_out   (o_out)
    );

endmodule

// ===== rtl/qpd_fifo.sv =====
// Two-entry queue between the sample front end and the Euler step sequencer.
module qpd_fifo #(
    parameter int WIDTH = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    import qpd_pkg::*;

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             n_wr_ptr;
    logic             n_rd_ptr;
    logic [1:0]       n_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = push_ok ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop_ok ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (push_ok && !pop_ok) begin
            n_count = r_count + 2'd1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/qpd_front.sv =====
// Sample front end: takes input transactions and rectifies each sample with saturation.
module qpd_front #(
    parameter int SAMPLE_BITS = 24
) (
    qpd_in_if.sink                 i_in,
    input  logic                   i_full,
    output logic                   o_push,
    output logic [SAMPLE_BITS-2:0] o_mag,
    output logic                   o_last
);
    import qpd_pkg::*;

    logic [SAMPLE_BITS-1:0] abs_val;

    // Two's complement magnitude; only the most negative code overflows.
    assign abs_val = i_in.sample[SAMPLE_BITS-1] ? (~i_in.sample + SAMPLE_BITS'(1))
                                                : i_in.sample;
    assign o_mag   = abs_val[SAMPLE_BITS-1] ? {(SAMPLE_BITS-1){1'b1}}
                                            : abs_val[SAMPLE_BITS-2:0];
    assign o_last  = i_in.last;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

endmodule

// ===== rtl/qpd_step.sv =====
// Euler step sequencer: charges or discharges the held detector level once per sample.
module qpd_step #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 24,
    parameter int LEVEL_W        = SAMPLE_BITS - 1 + COEF_FRAC_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    output logic                   o_q_pop,
    input  logic [SAMPLE_BITS-2:0] i_mag,
    input  logic                   i_last,
    input  logic [COEF_FRAC_BITS:0] i_charge_coef,
    input  logic [COEF_FRAC_BITS:0] i_discharge_coef,
    input  logic                   i_log_ready,
    output logic                   o_log_start,
    output logic [LEVEL_W-1:0]     o_level
);
    import qpd_pkg::*;

    localparam int F = COEF_FRAC_BITS;

    t_step_state        r_state;
    t_step_state        n_state;
    logic [LEVEL_W-1:0] r_level;
    logic [LEVEL_W-1:0] n_level;
    logic [LEVEL_W-1:0] r_oper;
    logic [LEVEL_W-1:0] n_oper;
    logic               r_charge;
    logic               n_charge;
    logic               r_last;
    logic               n_last;
    logic [LEVEL_W-1:0] r_p_hi;
    logic [LEVEL_W-1:0] n_p_hi;
    logic [F:0]         r_p_lo;
    logic [F:0]         n_p_lo;
    logic [LEVEL_W-1:0] r_delta;
    logic [LEVEL_W-1:0] n_delta;

    logic [LEVEL_W-1:0] vin;
    logic [F:0]         coef;
    logic [LEVEL_W:0]   prod_hi;
    logic [2*F:0]       prod_lo;
    logic [LEVEL_W-1:0] stepped;

    assign vin     = {i_mag, {F{1'b0}}};
    assign coef    = r_charge ? i_charge_coef : i_discharge_coef;
    // The operand is split at the binary point so each product stays narrow.
    assign prod_hi = r_oper[LEVEL_W-1:F] * coef;
    assign prod_lo = r_oper[F-1:0] * coef;
    assign stepped = r_charge ? (r_level + r_delta) : (r_level - r_delta);
    assign o_level = stepped;

    always_comb begin
        n_state     = r_state;
        n_level     = r_level;
        n_oper      = r_oper;
        n_charge    = r_charge;
        n_last      = r_last;
        n_p_hi      = r_p_hi;
        n_p_lo      = r_p_lo;
        n_delta     = r_delta;
        o_q_pop     = 1'b0;
        o_log_start = 1'b0;
        case (r_state)
            STEP_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop  = 1'b1;
                    n_last   = i_last;
                    n_charge = (vin > r_level);
                    n_oper   = (vin > r_level) ? (vin - r_level) : r_level;
                    n_state  = STEP_MUL;
                end
            end
            STEP_MUL: begin
                n_p_hi  = prod_hi[LEVEL_W-1:0];
                n_p_lo  = prod_lo[2*F:F];
                n_state = STEP_SUM;
            end
            STEP_SUM: begin
                n_delta = r_p_hi + LEVEL_W'(r_p_lo);
                n_state = STEP_UPD;
            end
            STEP_UPD: begin
                if (!r_last) begin
                    n_level = stepped;
                    n_state = STEP_IDLE;
                end else if (i_log_ready) begin
                    o_log_start = 1'b1;
                    n_level     = '0;
                    n_state     = STEP_IDLE;
                end
            end
            default: begin
                n_state = STEP_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STEP_IDLE;
            r_level <= '0;
        end else begin
            r_state <= n_state;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oper   <= n_oper;
        r_charge <= n_charge;
        r_last   <= n_last;
        r_p_hi   <= n_p_hi;
        r_p_lo   <= n_p_lo;
        r_delta  <= n_delta;
    end

endmodule

// ===== rtl/qpd_log.sv =====
// Level to dB converter: normalises, forms log2 by repeated squaring and scales to 1/128 dB.
module qpd_log #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 24,
    parameter int LEVEL_W        = SAMPLE_BITS - 1 + COEF_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [LEVEL_W-1:0] i_level,
    output logic               o_ready,
    qpd_out_if.source          o_out
);
    import qpd_pkg::*;

    localparam int EXP_W = $clog2(SAMPLE_BITS + COEF_FRAC_BITS) + 1;
    localparam int L2_W  = EXP_W + LOG_FRAC_W;
    localparam int PW    = L2_W + 27;
    localparam logic signed [PW-1:0] RND_HALF = PW'(64'sd2147483648);
    localparam logic signed [PW-1:0] SAT_HI   = PW'(DB_MAX);
    localparam logic signed [PW-1:0] SAT_LO   = PW'(DB_MIN);

    t_log_state                r_state;
    t_log_state                n_state;
    logic [LEVEL_W-1:0]        r_x;
    logic [LEVEL_W-1:0]        n_x;
    logic signed [EXP_W-1:0]   r_exp;
    logic signed [EXP_W-1:0]   n_exp;
    logic [MANT_W-1:0]         r_mant;
    logic [MANT_W-1:0]         n_mant;
    logic [LOG_FRAC_W-1:0]     r_frac;
    logic [LOG_FRAC_W-1:0]     n_frac;
    logic [SQR_CNT_W-1:0]      r_cnt;
    logic [SQR_CNT_W-1:0]      n_cnt;
    logic signed [PW-1:0]      r_prod;
    logic signed [PW-1:0]      n_prod;
    logic signed [DB_W-1:0]    r_db;
    logic signed [DB_W-1:0]    n_db;

    logic [LEVEL_W+MANT_W-1:0] padded;
    logic [2*MANT_W-1:0]       square;
    logic [MANT_W:0]           sq_top;
    logic signed [L2_W-1:0]    l2;
    logic signed [PW-1:0]      rnd_sum;
    logic signed [PW-1:0]      rnd_val;

    assign padded  = {r_x, {MANT_W{1'b0}}};
    assign square  = r_mant * r_mant;
    assign sq_top  = square[2*MANT_W-1:MANT_W-1];
    assign l2      = $signed({r_exp, r_frac});
    assign rnd_sum = r_prod + RND_HALF;
    assign rnd_val = rnd_sum >>> 32;

    assign o_ready        = (r_state == LOG_IDLE);
    assign o_out.valid    = (r_state == LOG_HOLD);
    assign o_out.level_db = r_db;

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_exp   = r_exp;
        n_mant  = r_mant;
        n_frac  = r_frac;
        n_cnt   = r_cnt;
        n_prod  = r_prod;
        n_db    = r_db;
        case (r_state)
            LOG_IDLE: begin
                if (i_start) begin
                    n_x     = i_level;
                    n_exp   = EXP_W'(SAMPLE_BITS - 2);
                    n_state = LOG_NORM;
                end
            end
            LOG_NORM: begin
                // One bit of left shift per cycle until the leading one reaches the top.
                if (r_x == '0) begin
                    n_db    = '0;
                    n_state = LOG_HOLD;
                end else if (r_x[LEVEL_W-1]) begin
                    n_mant  = padded[LEVEL_W+MANT_W-1:LEVEL_W];
                    n_frac  = '0;
                    n_cnt   = '0;
                    n_state = LOG_SQR;
                end else begin
                    n_x   = {r_x[LEVEL_W-2:0], 1'b0};
                    n_exp = r_exp - EXP_W'(1);
                end
            end
            LOG_SQR: begin
                // Each squaring yields one fraction bit of log2.
                n_frac = {r_frac[LOG_FRAC_W-2:0], sq_top[MANT_W]};
                n_mant = sq_top[MANT_W] ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];
                n_cnt  = r_cnt + SQR_CNT_W'(1);
                if (r_cnt == {SQR_CNT_W{1'b1}}) begin
                    n_state = LOG_MUL;
                end
            end
            LOG_MUL: begin
                n_prod  = l2 * DB_Q16;
                n_state = LOG_RND;
            end
            LOG_RND: begin
                if (rnd_val > SAT_HI) begin
                    n_db = DB_W'(DB_MAX);
                end else if (rnd_val < SAT_LO) begin
                    n_db = DB_W'(DB_MIN);
                end else begin
                    n_db = rnd_val[DB_W-1:0];
                end
                n_state = LOG_HOLD;
            end
            LOG_HOLD: begin
                if (o_out.ready) begin
                    n_state = LOG_IDLE;
                end
            end
            default: begin
                n_state = LOG_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LOG_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_exp  <= n_exp;
        r_mant <= n_mant;
        r_frac <= n_frac;
        r_cnt  <= n_cnt;
        r_prod <= n_prod;
        r_db   <= n_db;
    end

endmodule

// ===== sim/quasi_peak_detector_tb.sv =====
// Self-checking testbench for the quasi-peak detector: directed table, then random runs.
module quasi_peak_detector_tb;

    import qpd_pkg::*;

    localparam int SMP_W  = 24;
    localparam int FRAC_W = 24;

    // Largest rectified magnitude and the coefficient value of 1.0.
    localparam logic [63:0] MAG_MAX   = (64'd1 << (SMP_W - 1)) - 64'd1;
    localparam logic [63:0] COEF_ONE  = 64'd1 << FRAC_W;
    localparam logic [63:0] COEF_MASK = (64'd1 << (FRAC_W + 1)) - 64'd1;
    localparam logic [63:0] FRAC_MASK = COEF_ONE - 64'd1;

    // Register indexes that the block does not decode.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    // Settling time for a block still busy once the last result has left: two
    // queued samples, one step in flight and a full dB conversion (normalise,
    // square, scale and round), with margin.
    localparam int SETTLE      = 150;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 90;
    localparam int LIMIT       = 200000;
    localparam int N_ROWS      = 24;

    // One row of the directed table: either a register write or a sample.
    typedef struct {
        bit                   wr;
        logic [CFG_IDX_W-1:0] idx;
        int                   data;
        int                   smp;
        bit                   lst;
        bit                   typed;
        int                   db;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    qpd_in_if  #(.SAMPLE_BITS(SMP_W))     smp_ch ();
    qpd_out_if                            res_ch ();
    qpd_cfg_if #(.COEF_FRAC_BITS(FRAC_W)) reg_ch ();

    quasi_peak_detector #(
        .SAMPLE_BITS   (SMP_W),
        .COEF_FRAC_BITS(FRAC_W)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (smp_ch),
        .o_out  (res_ch),
        .i_cfg  (reg_ch)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: the two coefficients after capping and the held level,
    // in microvolts with FRAC_W fraction bits.
    logic [63:0] charge_k;
    logic [63:0] discharge_k;
    logic [63:0] qp_level;

    // Expected dB results, oldest first.
    logic signed [DB_W-1:0] db_expected [$];

    int bad_cnt      = 0;
    int db_checked   = 0;
    int samples_sent = 0;
    int runs_sent    = 0;
    int settings     = 0;
    int cycle_cnt    = 0;

    // Idling controls, set per phase by the stimulus process.
    int gap_pct   = 0;
    int stall_pct = 0;
    // A change of hold_req asks the receiver for one long hold-off.
    int hold_req  = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stall_left = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // floor(v * c / 2^FRAC_W), split at the binary point so nothing overflows.
    function automatic logic [63:0] scale_coef(logic [63:0] v, logic [63:0] c);
        logic [63:0] hi;
        logic [63:0] lo;
        hi = v >> FRAC_W;
        lo = v & FRAC_MASK;
        return hi * c + ((lo * c) >> FRAC_W);
    endfunction

    function automatic logic [63:0] cap_coef(logic [63:0] v);
        logic [63:0] m;
        m = v & COEF_MASK;
        return (m > COEF_ONE) ? COEF_ONE : m;
    endfunction

    // Non-zero level to 20*log10 in 1/128 dB: the log2 fraction comes from
    // sixteen truncating squarings of a Q30 mantissa, then the scale to dB is
    // rounded half up and saturated to the result width.
    function automatic logic signed [DB_W-1:0] db_of_level(logic [63:0] lv);
        int          msb;
        int          k;
        logic [63:0] x;
        longint      frac;
        longint      l2;
        longint      prod;
        longint      r;
        msb = 63;
        while (msb > 0 && lv[msb] == 1'b0)
            msb--;
        if (msb >= 30)
            x = lv >> (msb - 30);
        else
            x = lv << (30 - msb);
        frac = 0;
        for (k = 0; k < LOG_FRAC_W; k++) begin
            x    = (x * x) >> 30;
            frac = frac << 1;
            if (x >= (64'd1 << 31)) begin
                frac = frac | 1;
                x    = x >> 1;
            end
        end
        l2   = longint'(msb - FRAC_W) * 65536 + frac;
        prod = l2 * longint'(DB_Q16);
        r    = ((prod + (64'sd1 <<< 31) + (64'sd1 <<< 52)) >>> 32) - (64'sd1 <<< 20);
        if (r > DB_MAX)
            r = DB_MAX;
        if (r < DB_MIN)
            r = DB_MIN;
        return r[DB_W-1:0];
    endfunction

    // One Euler step on the held level; on the last sample of a run the
    // level is reported in dB and cleared.
    function automatic void advance_level(input logic signed [SMP_W-1:0] s, input bit lst,
                                          output bit has_db,
                                          output logic signed [DB_W-1:0] db);
        logic [SMP_W-1:0] raw;
        logic [63:0]      mag;
        logic [63:0]      vin;
        raw = s;
        if (raw[SMP_W-1])
            mag = 64'(SMP_W'(~raw + 1'b1));
        else
            mag = 64'(raw);
        // The most negative code has no positive twin and saturates.
        if (mag > MAG_MAX)
            mag = MAG_MAX;
        vin = mag << FRAC_W;
        // A sample equal to the level counts as discharge.
        if (vin > qp_level)
            qp_level = qp_level + scale_coef(vin - qp_level, charge_k);
        else
            qp_level = qp_level - scale_coef(qp_level, discharge_k);
        has_db = lst;
        db     = '0;
        if (lst) begin
            db       = (qp_level == 64'd0) ? '0 : db_of_level(qp_level);
            qp_level = 64'd0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Channel tasks
    // ------------------------------------------------------------------

    // Offers one sample, with an optional idle burst before it, and records
    // the expected dB result once the transaction completes. A typed value,
    // where given, stands in for the predicted one.
    task automatic push_sample(input logic signed [SMP_W-1:0] s, input bit lst,
                               input bit typed, input int typed_db);
        bit                     has_db;
        logic signed [DB_W-1:0] db;
        if ($urandom_range(0, 99) < gap_pct) begin
            smp_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        smp_ch.valid  <= 1'b1;
        smp_ch.sample <= s;
        smp_ch.last   <= lst;
        do @(posedge i_clk); while (!smp_ch.ready);
        advance_level(s, lst, has_db, db);
        if (has_db)
            db_expected.push_back(typed ? DB_W'(typed_db) : db);
        samples_sent++;
        if (lst)
            runs_sent++;
    endtask

    // Stops offering samples, waits for every expected result and then for
    // the block to finish any sample that gives no result.
    task automatic wait_idle();
        smp_ch.valid <= 1'b0;
        while (db_expected.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        reg_ch.valid <= 1'b1;
        reg_ch.index <= idx;
        reg_ch.data  <= data[FRAC_W:0];
        do @(posedge i_clk); while (!reg_ch.ready);
        case (t_cfg_idx'(idx))
            CFG_CHARGE_COEF:    charge_k    = cap_coef(data);
            CFG_DISCHARGE_COEF: discharge_k = cap_coef(data);
            default: ;
        endcase
        reg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random sample, biased towards the corners: full range, small values
    // around zero, the extremes, and repeats or negations of the previous
    // sample, which land exactly on the level when charging is at 1.0.
    function automatic logic signed [SMP_W-1:0] next_sample(logic signed [SMP_W-1:0] prev);
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return SMP_W'($urandom);
            4, 5: begin
                v = int'($urandom_range(0, 511)) - 256;
                return SMP_W'(v);
            end
            6: begin
                case ($urandom_range(0, 4))
                    0: return 24'sh7FFFFF;
                    1: return 24'sh800000;
                    2: return 24'sh000000;
                    3: return 24'sh000001;
                    default: return 24'shFFFFFF;
                endcase
            end
            7: return prev;
            8: return SMP_W'(-prev);
            default: begin
                v = int'($urandom_range(0, 131071)) - 65536;
                return SMP_W'(v);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Result ready: a long hold-off when asked for, otherwise random stall
    // bursts at the rate of the current phase.
    initial begin
        res_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(1, 7) - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    task automatic note_bad(input string what, input int want, input int got);
        bad_cnt++;
        if (bad_cnt <= 10)
            $display("tb: mismatch at cycle %0d, %s: expected %0d, got %0d",
                     cycle_cnt, what, want, got);
    endtask

    // Every completed result transaction is matched against the oldest
    // expectation; a result with nothing waiting is an error in itself.
    always @(posedge i_clk) begin
        logic signed [DB_W-1:0] want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (db_expected.size() == 0) begin
                note_bad("level_db with no result pending", 0, int'(res_ch.level_db));
            end else begin
                want = db_expected.pop_front();
                if (res_ch.level_db !== want)
                    note_bad("level_db", int'(want), int'(res_ch.level_db));
                db_checked++;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial begin
        t_stim_row              dir_rows [N_ROWS];
        logic signed [SMP_W-1:0] s;
        logic [63:0]            ck;
        logic [63:0]            dk;
        int                     r;
        int                     ph;
        int                     k;
        int                     left;
        int                     run_len;
        bit                     mid_done;

        // All inputs are known from the first instant.
        i_rst_n       <= 1'b0;
        smp_ch.valid  <= 1'b0;
        smp_ch.sample <= '0;
        smp_ch.last   <= 1'b0;
        reg_ch.valid  <= 1'b0;
        reg_ch.index  <= CFG_CHARGE_COEF;
        reg_ch.data   <= '0;

        charge_k    = 64'(CHARGE_COEF_RST);
        discharge_k = 64'(DISCHARGE_COEF_RST);
        qp_level    = 64'd0;

        // Directed table. Typed results are the ones that follow from the
        // arithmetic at sight: a zero level reports 0, and with charging at
        // 1.0 the level equals the sample, so powers of two give multiples
        // of 20*log10(2) dB (770.6 in 1/128 dB units).
        dir_rows = '{
            // Zero level at the end of a run, straight after reset.
            '{1'b0, CFG_CHARGE_COEF,    0,          0,        1'b1, 1'b1, 0},
            // Full-scale samples of both signs, the negative one saturating.
            '{1'b0, CFG_CHARGE_COEF,    0,          8388607,  1'b0, 1'b0, 0},
            '{1'b0, CFG_CHARGE_COEF,    0,          -8388608, 1'b0, 1'b0, 0},
            '{1'b0, CFG_CHARGE_COEF,    0,          -8388608, 1'b1, 1'b0, 0},
            '{1'b0, CFG_CHARGE_COEF,    0,          1000,     1'b0, 1'b0, 0},
            '{1'b0, CFG_CHARGE_COEF,    0,          -1000,    1'b1, 1'b0, 0},
            // All-ones charge write is capped at 1.0; no discharge at all.
            '{1'b1, CFG_CHARGE_COEF,    'h1FFFFFF,  0,        1'b0, 1'b0, 0},
            '{1'b1, CFG_DISCHARGE_COEF, 0,          0,        1'b0, 1'b0, 0},
            '{1'b0, CFG_CHARGE_COEF,    0,          1,        1'b1, 1'b1, 0},
            '{1'b0, CFG_CHARGE_COEF,    0,          -2,       1'b1, 1'b1, 771},
            '{1'b0, CFG_CHARGE_COEF,    0,          1024,     1'b1, 1'b1, 7706},
            // A sample equal to the level takes the discharge branch.
            '{1'b0, CFG_CHARGE_COEF,    0,          8388607,  1'b0, 1'b0, 0},
            '{1'b0, CFG_CHARGE_COEF,    0,          8388607,  1'b0, 1'b0, 0},
            '{1'b0, CFG_CHARGE_COEF,    0,          -8388608, 1'b1, 1'b0, 0},
            // Discharge at exactly 1.0 empties the level in one step.
            '{1'b1, CFG_DISCHARGE_COEF, 'h1000000,  0,        1'b0, 1'b0, 0},
            '{1'b0, CFG_CHARGE_COEF,    0,          5000,     1'b0, 1'b0, 0},
            '{1'b0, CFG_CHARGE_COEF,    0,          0,        1'b1, 1'b1, 0},
            // Smallest coefficients: the level creeps to one LSB and the
            // truncating discharge step cannot take it back to zero.
            '{1'b1, CFG_CHARGE_COEF,    1,          0,        1'b0, 1'b0, 0},
            '{1'b1, CFG_DISCHARGE_COEF, 1,          0,        1'b0, 1'b0, 0},
            '{1'b0, CFG_CHARGE_COEF,    0,          1,        1'b0, 1'b0, 0},
            '{1'b0, CFG_CHARGE_COEF,    0,          0,        1'b1, 1'b0, 0},
            // Writes to undecoded indexes must leave both coefficients alone.
            '{1'b1, CFG_SPARE_2,        0,          0,        1'b0, 1'b0, 0},
            '{1'b1, CFG_SPARE_3,        'h1FFFFFF,  0,        1'b0, 1'b0, 0},
            '{1'b0, CFG_CHARGE_COEF,    0,          7,        1'b1, 1'b0, 0}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gap_pct   = 30;
        stall_pct = 30;
        for (r = 0; r < N_ROWS; r++) begin
            if (dir_rows[r].wr) begin
                wait_idle();
                write_reg(dir_rows[r].idx, 64'(dir_rows[r].data));
                settings++;
            end else begin
                push_sample(SMP_W'(dir_rows[r].smp), dir_rows[r].lst,
                            dir_rows[r].typed, dir_rows[r].db);
            end
        end

        // Random phases. Each starts from an idle block with a fresh pair of
        // coefficients; runs of random length end on a last sample, so most
        // of the traffic is complete observation runs with random content.
        s = '0;
        for (ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    // Full 25-bit values, often above 1.0 and so capped.
                    ck = 64'($urandom_range(0, 32'h1FFFFFF));
                    dk = 64'($urandom_range(0, 32'h1FFFFFF));
                end
                1: begin
                    ck = 64'(CHARGE_COEF_RST);
                    dk = 64'(DISCHARGE_COEF_RST);
                end
                2: begin
                    ck = COEF_ONE;
                    dk = 64'd0;
                end
                3: begin
                    ck = 64'd0;
                    dk = 64'($urandom_range(0, 32'h1000000));
                end
                4: begin
                    ck = 64'($urandom_range(1, 4096));
                    dk = 64'($urandom_range(1, 4096));
                end
                default: begin
                    ck = 64'($urandom_range(32'h800000, 32'h1000000));
                    dk = 64'($urandom_range(0, 32'h100000));
                end
            endcase
            write_reg(CFG_CHARGE_COEF, ck);
            write_reg(CFG_DISCHARGE_COEF, dk);
            settings++;

            // Phase 3 is a stretch with no idling at all, and the last phase
            // runs flat out on both sides.
            gap_pct   = (ph == 3 || ph == PHASES - 1) ? 0 : 30;
            stall_pct = (ph == 3 || ph == PHASES - 1) ? 0 : 30;

            // In the reset-coefficient phase the receiver stops for a long
            // while under a burst of short runs, so the result register, the
            // converter and the sample queue all fill and the input stalls.
            if (ph == 1)
                hold_req++;

            mid_done = 1'b0;
            left     = PHASE_ITEMS;
            while (left > 0) begin
                // Half way through one phase the sender pauses until every
                // result is out, with no register write after it.
                if (ph == 4 && !mid_done && left <= PHASE_ITEMS / 2) begin
                    wait_idle();
                    mid_done = 1'b1;
                end
                if (ph == 1 && PHASE_ITEMS - left < 40)
                    run_len = $urandom_range(1, 2);
                else if ($urandom_range(0, 7) == 0)
                    run_len = $urandom_range(20, 60);
                else
                    run_len = $urandom_range(1, 12);
                if (run_len > left)
                    run_len = left;
                for (k = 0; k < run_len; k++) begin
                    s = next_sample(s);
                    push_sample(s, k == run_len - 1, 1'b0, 0);
                end
                left -= run_len;
            end
        end

        // Drain and allow the block time to show any stray result.
        wait_idle();
        repeat (SETTLE) @(posedge i_clk);

        $display("tb: %0d samples in %0d runs, %0d dB results checked, %0d coefficient settings",
                 samples_sent, runs_sent, db_checked, settings);
        $display("tb: included capped and unused register writes and a %0d-cycle result hold-off",
                 HOLD_CYCLES);
        if (bad_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: %0d mismatches", bad_cnt);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
